[rtl/indexed_min_heap_queue_top_defines.svh]
// Assertion macros used by the heap queue top level.
`ifndef INDEXED_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IMHQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IMHQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/imhq_pkg.sv]
// Shared types, constants and command codes for the heap queue.
`default_nettype none
package imhq_pkg;

  localparam int ID_W   = 8;
  localparam int KEY_W  = 32;
  localparam int SLOT_W = 8;
  localparam int CNT_W  = 8;
  localparam int CAP_W  = 8;
  localparam int ACT_W  = 2;
  localparam int ST_W   = 3;
  localparam int DEPTH  = 1 << SLOT_W;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd255;
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_QUERY  = 2'd3
  } act_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_PRESENT = 3'd3,
    ST_ABSENT  = 3'd4,
    ST_RANGE   = 3'd5
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_SLOT, RD_LAST, RD_PARENT, RD_LEFT, RD_RIGHT, RD_POSD, RD_TOP
  } rd_sel_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_SET_STATUS, OP_INS_START, OP_REM_TOP, OP_REM_POS,
    OP_CAP_GONE, OP_CAP_LAST, OP_UP_MOVE, OP_PLACE, OP_DN_CAPL, OP_DN_CAPR,
    OP_DN_MOVE, OP_Q_CAP, OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd;
    logic    pos_rd;
    status_t code;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic in_range;
    logic present;
    logic empty;
    logic full;
    logic slot_gt1;
    logic up_less;
    logic moved;
    logic s_le_cnt;
    logic l_le_cnt;
    logic r_le_cnt;
    logic dn_less;
    logic out_busy;
  } flags_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOKUP, S_DECIDE, S_RM_RDS, S_RM_RDL, S_RM_CLR, S_RM_CHK,
    S_UP_CHK, S_UP_CMP, S_DN_CHK, S_DN_L, S_DN_R, S_DN_CMP, S_POST,
    S_TOP_RD, S_DONE
  } fsm_t;

endpackage
`default_nettype wire

[rtl/imhq_ifs.sv]
// Request and result channel interfaces for the heap queue.
`default_nettype none
interface imhq_req_if import imhq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [ID_W-1:0]   element_id;
  logic signed [KEY_W-1:0] priority_key;

  modport source (output valid, action, element_id, priority_key, input ready);
  modport sink   (input valid, action, element_id, priority_key, output ready);
endinterface

interface imhq_rsp_if import imhq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic              top_valid;
  logic [ID_W-1:0]   top_element;
  logic signed [KEY_W-1:0] top_key;
  logic              query_present;
  logic signed [KEY_W-1:0] query_key;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, status, top_valid, top_element, top_key,
                  query_present, query_key, entry_count, input ready);
  modport sink   (input valid, status, top_valid, top_element, top_key,
                  query_present, query_key, entry_count, output ready);
endinterface
`default_nettype wire

[rtl/indexed_min_heap_queue_top.sv]
// An insert sifts the new entry up; a remove sifts the entry moved into the freed slot
// up or down. Update runs a remove and an insert. Requests are taken one at a time,
// the next in the cycle after the result beat is loaded, even while that beat waits.
// Reset: synchronous active-low; queue empty, position valid bits cleared,
// capacity 255, heap slot contents undefined until written.
`default_nettype none
`include "indexed_min_heap_queue_top_defines.svh"
module indexed_min_heap_queue_top import imhq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  imhq_req_if.sink               in_ch,
  imhq_rsp_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic [CAP_W-1:0] cap_r;
  flags_t           flg;
  cmd_t             cmd;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1] == REG_CAPACITY);
  assign prdata  = reg_hit ? APB_DW'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  imhq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .flg      (flg),
    .cmd      (cmd)
  );

  imhq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cap               (cap_r),
    .cmd               (cmd),
    .in_action         (in_ch.action),
    .in_element_id     (in_ch.element_id),
    .in_priority_key   (in_ch.priority_key),
    .flg               (flg),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_top_valid     (out_ch.top_valid),
    .out_top_element   (out_ch.top_element),
    .out_top_key       (out_ch.top_key),
    .out_query_present (out_ch.query_present),
    .out_query_key     (out_ch.query_key),
    .out_entry_count   (out_ch.entry_count)
  );

  `IMHQ_ASSERT_NXT(a_busy_after_beat, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after beat")
  `IMHQ_ASSERT_IMP(a_top_matches_count, out_ch.valid, out_ch.top_valid == (out_ch.entry_count != '0), "top valid vs count")
  `IMHQ_ASSERT_IMP(a_query_ok, out_ch.valid && out_ch.query_present, out_ch.status == ST_OK, "query status")

endmodule
`default_nettype wire

[rtl/imhq_dp.sv]
// Heap queue datapath: heap and position memories, work registers, result beat.
`default_nettype none
module imhq_dp import imhq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CAP_W-1:0]  cap,
  input  wire cmd_t              cmd,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [ID_W-1:0]   in_element_id,
  input  wire logic [KEY_W-1:0]  in_priority_key,
  output flags_t                 flg,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [ST_W-1:0]        out_status,
  output logic                   out_top_valid,
  output logic [ID_W-1:0]        out_top_element,
  output logic [KEY_W-1:0]       out_top_key,
  output logic                   out_query_present,
  output logic [KEY_W-1:0]       out_query_key,
  output logic [CNT_W-1:0]       out_entry_count
);

  entry_t             heap_mem [DEPTH];
  logic [SLOT_W-1:0]  pos_mem  [DEPTH];
  logic [DEPTH-1:0]   pos_vld_r;

  act_t               act_r;
  logic [ID_W-1:0]    op_id_r;
  logic [KEY_W-1:0]   op_key_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [SLOT_W-1:0]  cslot_r;
  entry_t             cur_r;
  entry_t             child_r;
  entry_t             hrd_r;
  logic [ID_W-1:0]    gone_r;
  logic [SLOT_W-1:0]  prd_r;
  logic               moved_r;
  logic [ST_W-1:0]    status_r;
  logic               qp_r;
  logic [KEY_W-1:0]   qk_r;
  logic               out_valid_r;
  logic [ST_W-1:0]    o_status_r;
  logic               o_top_valid_r;
  logic [ID_W-1:0]    o_top_element_r;
  logic [KEY_W-1:0]   o_top_key_r;
  logic               o_qp_r;
  logic [KEY_W-1:0]   o_qk_r;
  logic [CNT_W-1:0]   o_cnt_r;

  logic [SLOT_W:0]    left_w;
  logic [SLOT_W:0]    right_w;
  logic [SLOT_W-1:0]  h_addr;
  logic               h_we;
  logic [SLOT_W-1:0]  h_waddr;
  entry_t             h_wdata;
  logic               p_we;
  logic [ID_W-1:0]    p_waddr;
  logic [SLOT_W-1:0]  p_wdata;
  logic               top_nz;

  assign left_w  = {slot_r, 1'b0};
  assign right_w = left_w + (SLOT_W+1)'(1);
  assign top_nz  = (cnt_r != '0);

  always_comb begin
    unique case (cmd.rd)
      RD_SLOT:   h_addr = slot_r;
      RD_LAST:   h_addr = cnt_r;
      RD_PARENT: h_addr = slot_r >> 1;
      RD_LEFT:   h_addr = left_w[SLOT_W-1:0];
      RD_RIGHT:  h_addr = right_w[SLOT_W-1:0];
      RD_POSD:   h_addr = prd_r;
      RD_TOP:    h_addr = SLOT_W'(1);
      default:   h_addr = slot_r;
    endcase
  end

  always_comb begin
    h_we    = 1'b0;
    h_waddr = slot_r;
    h_wdata = cur_r;
    p_we    = 1'b0;
    p_waddr = cur_r.id;
    p_wdata = slot_r;
    unique case (cmd.op)
      OP_UP_MOVE: begin
        h_we    = 1'b1;
        h_wdata = hrd_r;
        p_we    = 1'b1;
        p_waddr = hrd_r.id;
      end
      OP_DN_MOVE: begin
        h_we    = 1'b1;
        h_wdata = child_r;
        p_we    = 1'b1;
        p_waddr = child_r.id;
      end
      OP_PLACE: begin
        h_we = 1'b1;
        p_we = 1'b1;
      end
      OP_CAP_LAST: begin
        p_we    = 1'b1;
        p_waddr = gone_r;
        p_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      heap_mem[h_waddr] <= h_wdata;
    end
    if (cmd.rd != RD_NONE) begin
      hrd_r <= heap_mem[h_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pos_mem[p_waddr] <= p_wdata;
    end
    if (cmd.pos_rd) begin
      prd_r <= pos_vld_r[op_id_r] ? pos_mem[op_id_r] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_vld_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (p_we) begin
        pos_vld_r[p_waddr] <= 1'b1;
      end
      if (cmd.op == OP_INS_START) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.op == OP_CAP_LAST) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (cmd.op == OP_RESULT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        act_r    <= act_t'(in_action);
        op_id_r  <= in_element_id;
        op_key_r <= in_priority_key;
        status_r <= ST_OK;
        qp_r     <= 1'b0;
        qk_r     <= '0;
      end
      OP_SET_STATUS: status_r <= cmd.code;
      OP_INS_START: begin
        slot_r  <= cnt_r + SLOT_W'(1);
        cur_r   <= '{id: op_id_r, key: op_key_r};
        moved_r <= 1'b0;
      end
      OP_REM_TOP: slot_r <= SLOT_W'(1);
      OP_REM_POS: slot_r <= prd_r;
      OP_CAP_GONE: gone_r <= hrd_r.id;
      OP_CAP_LAST: begin
        cur_r   <= hrd_r;
        moved_r <= 1'b0;
      end
      OP_UP_MOVE: begin
        slot_r  <= slot_r >> 1;
        moved_r <= 1'b1;
      end
      OP_DN_CAPL: begin
        child_r <= hrd_r;
        cslot_r <= left_w[SLOT_W-1:0];
      end
      OP_DN_CAPR: begin
        if ($signed(hrd_r.key) < $signed(child_r.key)) begin
          child_r <= hrd_r;
          cslot_r <= right_w[SLOT_W-1:0];
        end
      end
      OP_DN_MOVE: begin
        slot_r  <= cslot_r;
        moved_r <= 1'b1;
      end
      OP_Q_CAP: begin
        qp_r <= 1'b1;
        qk_r <= hrd_r.key;
      end
      OP_RESULT: begin
        o_status_r      <= status_r;
        o_top_valid_r   <= top_nz;
        o_top_element_r <= top_nz ? hrd_r.id : '0;
        o_top_key_r     <= top_nz ? hrd_r.key : '0;
        o_qp_r          <= qp_r;
        o_qk_r          <= qk_r;
        o_cnt_r         <= cnt_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    flg.act      = act_r;
    flg.in_range = (op_id_r <= cap);
    flg.present  = (prd_r != '0);
    flg.empty    = (cnt_r == '0);
    flg.full     = (cnt_r >= cap);
    flg.slot_gt1 = (slot_r > SLOT_W'(1));
    flg.up_less  = ($signed(cur_r.key) < $signed(hrd_r.key));
    flg.moved    = moved_r;
    flg.s_le_cnt = (slot_r <= cnt_r);
    flg.l_le_cnt = (left_w <= {1'b0, cnt_r});
    flg.r_le_cnt = (right_w <= {1'b0, cnt_r});
    flg.dn_less  = ($signed(child_r.key) < $signed(cur_r.key));
    flg.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = o_status_r;
  assign out_top_valid     = o_top_valid_r;
  assign out_top_element   = o_top_element_r;
  assign out_top_key       = o_top_key_r;
  assign out_query_present = o_qp_r;
  assign out_query_key     = o_qk_r;
  assign out_entry_count   = o_cnt_r;

endmodule
`default_nettype wire

[rtl/imhq_ctrl.sv]
// Heap queue controller: sequences lookups, sift walks and the result beat.
`default_nettype none
module imhq_ctrl import imhq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire flags_t flg,
  output cmd_t        cmd
);

  fsm_t state_r, state_nxt;
  logic rem_mode_r, rem_mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rem_mode_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rem_mode_r <= rem_mode_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    rem_mode_nxt = rem_mode_r;
    in_ready     = 1'b0;
    cmd          = '{op: OP_NONE, rd: RD_NONE, pos_rd: 1'b0, code: ST_OK};
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.pos_rd = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_TOP_RD;
        cmd.op    = OP_SET_STATUS;
        unique case (flg.act)
          ACT_INSERT: begin
            priority if (!flg.in_range) cmd.code = ST_RANGE;
            else if (flg.present) cmd.code = ST_PRESENT;
            else if (flg.full) cmd.code = ST_FULL;
            else begin
              cmd.op       = OP_INS_START;
              rem_mode_nxt = 1'b0;
              state_nxt    = S_UP_CHK;
            end
          end
          ACT_REMOVE: begin
            if (flg.empty) begin
              cmd.code = ST_EMPTY;
            end else begin
              cmd.op       = OP_REM_TOP;
              rem_mode_nxt = 1'b1;
              state_nxt    = S_RM_RDS;
            end
          end
          ACT_UPDATE: begin
            priority if (!flg.in_range) cmd.code = ST_RANGE;
            else if (!flg.present) cmd.code = ST_ABSENT;
            else begin
              cmd.op       = OP_REM_POS;
              rem_mode_nxt = 1'b1;
              state_nxt    = S_RM_RDS;
            end
          end
          ACT_QUERY: begin
            priority if (!flg.in_range) cmd.code = ST_RANGE;
            else if (!flg.present) cmd.code = ST_ABSENT;
            else begin
              cmd.op    = OP_NONE;
              cmd.rd    = RD_POSD;
              state_nxt = S_DONE;
            end
          end
          default: begin
          end
        endcase
        if (flg.act == ACT_QUERY && flg.in_range && flg.present) begin
          state_nxt = S_POST;
        end
      end
      S_RM_RDS: begin
        cmd.rd    = RD_SLOT;
        state_nxt = S_RM_RDL;
      end
      S_RM_RDL: begin
        cmd.op    = OP_CAP_GONE;
        cmd.rd    = RD_LAST;
        state_nxt = S_RM_CLR;
      end
      S_RM_CLR: begin
        cmd.op    = OP_CAP_LAST;
        state_nxt = S_RM_CHK;
      end
      S_RM_CHK: begin
        state_nxt = flg.s_le_cnt ? S_UP_CHK : S_POST;
      end
      S_UP_CHK: begin
        priority if (flg.slot_gt1) begin
          cmd.rd    = RD_PARENT;
          state_nxt = S_UP_CMP;
        end else if (rem_mode_r && !flg.moved) begin
          state_nxt = S_DN_CHK;
        end else begin
          cmd.op    = OP_PLACE;
          state_nxt = S_POST;
        end
      end
      S_UP_CMP: begin
        priority if (flg.up_less) begin
          cmd.op    = OP_UP_MOVE;
          state_nxt = S_UP_CHK;
        end else if (rem_mode_r && !flg.moved) begin
          state_nxt = S_DN_CHK;
        end else begin
          cmd.op    = OP_PLACE;
          state_nxt = S_POST;
        end
      end
      S_DN_CHK: begin
        if (flg.l_le_cnt) begin
          cmd.rd    = RD_LEFT;
          state_nxt = S_DN_L;
        end else begin
          cmd.op    = OP_PLACE;
          state_nxt = S_POST;
        end
      end
      S_DN_L: begin
        cmd.op = OP_DN_CAPL;
        if (flg.r_le_cnt) begin
          cmd.rd    = RD_RIGHT;
          state_nxt = S_DN_R;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_R: begin
        cmd.op    = OP_DN_CAPR;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (flg.dn_less) begin
          cmd.op    = OP_DN_MOVE;
          state_nxt = S_DN_CHK;
        end else begin
          cmd.op    = OP_PLACE;
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        priority if (flg.act == ACT_QUERY) begin
          cmd.op    = OP_Q_CAP;
          state_nxt = S_TOP_RD;
        end else if (rem_mode_r && flg.act == ACT_UPDATE) begin
          cmd.op       = OP_INS_START;
          rem_mode_nxt = 1'b0;
          state_nxt    = S_UP_CHK;
        end else begin
          state_nxt = S_TOP_RD;
        end
      end
      S_TOP_RD: begin
        cmd.rd    = RD_TOP;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!flg.out_busy) begin
          cmd.op    = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire
